// File: design/smda_pkg.sv
`default_nettype none

package smda_pkg;

  localparam int WORD_W    = 32;
  localparam int WORDS_DEF = 4;
  localparam int DIG_PER_WORD = 10;   // decimal digits per 32-bit word, upper bound
  localparam int TEN       = 10;

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_DIGIT = 3'd1;
  localparam logic [2:0] OP_LOAD  = 3'd2;
  localparam logic [2:0] OP_ADD   = 3'd3;
  localparam logic [2:0] OP_SUB   = 3'd4;
  localparam logic [2:0] OP_PRINT = 3'd5;

  typedef enum logic {
    ALU_ADD,
    ALU_MUL10
  } alu_mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WORD,
    ST_DABBLE,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    PASS_MUL,
    PASS_LOAD,
    PASS_ADD,
    PASS_MAG
  } pass_e;

  typedef struct packed {
    alu_mode_e         mode;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [3:0]        cin;
  } alu_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] res;
    logic [3:0]        cout;
  } alu_rsp_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic shift_bit;
    logic advance;
  } bcd_ctl_t;

endpackage

`default_nettype wire

// File: design/smda_word_alu.sv
`default_nettype none

module smda_word_alu
  import smda_pkg::*;
(
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [WORD_W+3:0] prod;
  logic [WORD_W:0]   sum;

  // word times ten plus incoming carry, or a plain add with carry
  assign prod = ({4'b0, req_i.a} * (WORD_W + 4)'(TEN)) + (WORD_W + 4)'(req_i.cin);
  assign sum  = {1'b0, req_i.a} + {1'b0, req_i.b} + (WORD_W + 1)'(req_i.cin[0]);

  always_comb begin
    unique case (req_i.mode)
      ALU_MUL10: begin
        rsp_o.res  = prod[WORD_W-1:0];
        rsp_o.cout = prod[WORD_W+3:WORD_W];
      end
      ALU_ADD: begin
        rsp_o.res  = sum[WORD_W-1:0];
        rsp_o.cout = {3'b0, sum[WORD_W]};
      end
      default: begin
        rsp_o.res  = sum[WORD_W-1:0];
        rsp_o.cout = {3'b0, sum[WORD_W]};
      end
    endcase
  end

endmodule

`default_nettype wire

// File: design/smda_bcd_conv.sv
`default_nettype none

module smda_bcd_conv
  import smda_pkg::*;
#(
  parameter int DIGITS = DIG_PER_WORD * WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  bcd_ctl_t   ctl_i,
  output logic [3:0] top_digit_o
);

  localparam int BW = 4 * DIGITS;

  logic [BW-1:0] bcd_q, bcd_d;
  logic [BW-1:0] adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    priority if (ctl_i.clear) begin
      bcd_d = '0;
    end else if (ctl_i.dabble) begin
      bcd_d = {adj[BW-2:0], ctl_i.shift_bit};
    end else if (ctl_i.advance) begin
      bcd_d = {bcd_q[BW-5:0], 4'b0};
    end else begin
      bcd_d = bcd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcd_q <= '0;
    end else begin
      bcd_q <= bcd_d;
    end
  end

  assign top_digit_o = bcd_q[BW-1 -: 4];

endmodule

`default_nettype wire

// File: design/signed_multiword_decimal_accumulator_core.sv
`default_nettype none

// Signed decimal accumulator of W = 32*WORDS bits, two's complement. Enter an
// operand as a start beat (with its sign) followed by digit beats, then load,
// add or subtract it into the accumulator, all modulo 2^W. A print beat
// produces an optional minus-sign beat and then the magnitude's decimal
// digits, most significant first, without leading zeros, the final one
// marked last. All word arithmetic runs through one 32-bit word unit under a small
// sequencer, one word per cycle. Start and the unused codes are done on
// acceptance; digit, load, add and subtract then step through the words. A
// print forms the magnitude word by word, converts it by shift-and-add-three,
// emits a minus-sign beat when the value is negative, skips leading zeros,
// then emits the digit beats; the sign and digit steps stretch while the
// output register is full and the sink is not ready. The input is not ready
// while an item is in progress; the output register lets a new item enter
// while the final result beat still waits.

module signed_multiword_decimal_accumulator_core
  import smda_pkg::*;
#(
  parameter int WORDS = WORDS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,

  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] operation_i,
  input  logic [3:0] digit_i,
  input  logic       negative_i,

  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       is_sign_o,
  output logic [3:0] out_digit_o,
  output logic       last_o
);

  localparam int W      = WORD_W * WORDS;
  localparam int DIGITS = DIG_PER_WORD * WORDS;
  localparam int WCW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BCW    = $clog2(W);
  localparam int DCW    = $clog2(DIGITS + 1);

  // architectural state, word 0 least significant
  logic [WORD_W-1:0] acc_q [WORDS];
  logic [WORD_W-1:0] acc_d [WORDS];
  logic [WORD_W-1:0] opnd_q [WORDS];
  logic [WORD_W-1:0] opnd_d [WORDS];
  logic              neg_q, neg_d;

  // sequencer
  state_e            state_q, state_d;
  pass_e             pass_q, pass_d;
  logic              invert_q, invert_d;
  logic              minus_q, minus_d;
  logic [3:0]        carry_q, carry_d;
  logic [WCW-1:0]    word_cnt_q, word_cnt_d;
  logic [BCW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DCW-1:0]    dig_cnt_q, dig_cnt_d;
  logic [W-1:0]      mag_q, mag_d;

  // output register
  logic              out_valid_q, out_valid_d;
  logic              is_sign_q, is_sign_d;
  logic [3:0]        out_digit_q, out_digit_d;
  logic              last_q, last_d;

  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  bcd_ctl_t          bcd_ctl;
  logic [3:0]        top_digit;
  logic              in_fire;
  logic              out_free;

  smda_word_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  smda_bcd_conv #(
    .DIGITS (DIGITS)
  ) u_bcd (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (bcd_ctl),
    .top_digit_o (top_digit)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  // the output register may take a new beat when empty or being drained
  assign out_free   = !out_valid_q || out_ready_i;

  // Shared word unit: operand word 0 and accumulator word 0 are always the
  // ones in play, the arrays rotate down by one word per step.
  always_comb begin
    alu_req.cin  = carry_q;
    alu_req.mode = ALU_ADD;
    alu_req.a    = '0;
    alu_req.b    = '0;
    unique case (pass_q)
      PASS_MUL: begin
        alu_req.mode = ALU_MUL10;
        alu_req.a    = opnd_q[0];
      end
      PASS_LOAD: begin
        alu_req.b = invert_q ? ~opnd_q[0] : opnd_q[0];
      end
      PASS_ADD: begin
        alu_req.a = acc_q[0];
        alu_req.b = invert_q ? ~opnd_q[0] : opnd_q[0];
      end
      PASS_MAG: begin
        alu_req.b = invert_q ? ~acc_q[0] : acc_q[0];
      end
      default: begin
        alu_req.mode = ALU_ADD;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    invert_d    = invert_q;
    minus_d     = minus_q;
    carry_d     = carry_q;
    word_cnt_d  = word_cnt_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    acc_d       = acc_q;
    opnd_d      = opnd_q;
    bcd_ctl     = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    is_sign_d   = is_sign_q;
    out_digit_d = out_digit_q;
    last_d      = last_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          word_cnt_d = WCW'(WORDS - 1);
          unique case (operation_i)
            OP_START: begin
              for (int i = 0; i < WORDS; i++) begin
                opnd_d[i] = '0;
              end
              neg_d = negative_i;
            end
            OP_DIGIT: begin
              pass_d  = PASS_MUL;
              carry_d = digit_i;
              state_d = ST_WORD;
            end
            OP_LOAD: begin
              pass_d   = PASS_LOAD;
              invert_d = neg_q;
              carry_d  = {3'b0, neg_q};
              state_d  = ST_WORD;
            end
            OP_ADD: begin
              pass_d   = PASS_ADD;
              invert_d = neg_q;
              carry_d  = {3'b0, neg_q};
              state_d  = ST_WORD;
            end
            OP_SUB: begin
              // subtracting a negative operand adds its magnitude
              pass_d   = PASS_ADD;
              invert_d = !neg_q;
              carry_d  = {3'b0, !neg_q};
              state_d  = ST_WORD;
            end
            OP_PRINT: begin
              minus_d       = acc_q[WORDS-1][WORD_W-1];
              pass_d        = PASS_MAG;
              invert_d      = acc_q[WORDS-1][WORD_W-1];
              carry_d       = {3'b0, acc_q[WORDS-1][WORD_W-1]};
              bcd_ctl.clear = 1'b1;
              state_d       = ST_WORD;
            end
            default: begin
              // unused codes: drop the beat
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      ST_WORD: begin
        carry_d = alu_rsp.cout;
        unique case (pass_q)
          PASS_MUL: begin
            for (int i = 0; i < WORDS - 1; i++) begin
              opnd_d[i] = opnd_q[i+1];
            end
            opnd_d[WORDS-1] = alu_rsp.res;
          end
          PASS_LOAD, PASS_ADD: begin
            for (int i = 0; i < WORDS - 1; i++) begin
              opnd_d[i] = opnd_q[i+1];
              acc_d[i]  = acc_q[i+1];
            end
            opnd_d[WORDS-1] = opnd_q[0];
            acc_d[WORDS-1]  = alu_rsp.res;
          end
          PASS_MAG: begin
            for (int i = 0; i < WORDS - 1; i++) begin
              acc_d[i] = acc_q[i+1];
            end
            acc_d[WORDS-1] = acc_q[0];
            mag_d = (mag_q >> WORD_W) | (W'(alu_rsp.res) << (W - WORD_W));
          end
          default: begin
            carry_d = alu_rsp.cout;
          end
        endcase
        if (word_cnt_q == '0) begin
          if (pass_q == PASS_MAG) begin
            bit_cnt_d = BCW'(W - 1);
            state_d   = ST_DABBLE;
          end else begin
            state_d = ST_IDLE;
          end
        end else begin
          word_cnt_d = word_cnt_q - 1'b1;
        end
      end

      ST_DABBLE: begin
        // feed the magnitude in, most significant bit first
        bcd_ctl.dabble    = 1'b1;
        bcd_ctl.shift_bit = mag_q[W-1];
        mag_d             = {mag_q[W-2:0], 1'b0};
        bit_cnt_d         = bit_cnt_q - 1'b1;
        if (bit_cnt_q == '0) begin
          dig_cnt_d = DCW'(DIGITS);
          state_d   = minus_q ? ST_SIGN : ST_SKIP;
        end
      end

      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          is_sign_d   = 1'b1;
          out_digit_d = '0;
          last_d      = 1'b0;
          state_d     = ST_SKIP;
        end
      end

      ST_SKIP: begin
        // drop leading zeros, always keep the units digit
        if ((top_digit == '0) && (dig_cnt_q > DCW'(1))) begin
          bcd_ctl.advance = 1'b1;
          dig_cnt_d       = dig_cnt_q - 1'b1;
        end else begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          is_sign_d       = 1'b0;
          out_digit_d     = top_digit;
          last_d          = (dig_cnt_q == DCW'(1));
          bcd_ctl.advance = 1'b1;
          dig_cnt_d       = dig_cnt_q - 1'b1;
          if (dig_cnt_q == DCW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pass_q      <= PASS_MUL;
      invert_q    <= 1'b0;
      minus_q     <= 1'b0;
      carry_q     <= '0;
      word_cnt_q  <= '0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WORDS; i++) begin
        acc_q[i]  <= '0;
        opnd_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      invert_q    <= invert_d;
      minus_q     <= minus_d;
      carry_q     <= carry_d;
      word_cnt_q  <= word_cnt_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
      neg_q       <= neg_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      opnd_q      <= opnd_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    mag_q       <= mag_d;
    is_sign_q   <= is_sign_d;
    out_digit_q <= out_digit_d;
    last_q      <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign is_sign_o   = is_sign_q;
  assign out_digit_o = out_digit_q;
  assign last_o      = last_q;

  // a digit leaving the converter must be a valid decimal digit
  a_emit_bcd_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (top_digit <= 4'd9))
    else $error("converter produced a non-decimal digit");

  // digit count never runs out while digits remain to be sent
  a_dig_cnt_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) || (state_q == ST_SKIP)) |-> (dig_cnt_q != '0))
    else $error("digit count exhausted during a print");

  // the sign beat is never the final beat of a print
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_sign_o) |-> !last_o)
    else $error("minus sign marked as last");

  // a print always keeps the block busy for at least the next cycle
  a_print_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (operation_i == OP_PRINT)) |=> !in_ready_o)
    else $error("print accepted without starting work");

  // word counter stays within the word range
  a_word_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WORD) |-> (word_cnt_q <= WCW'(WORDS - 1)))
    else $error("word counter out of range");

endmodule

`default_nettype wire

// File: dv/signed_multiword_decimal_accumulator_core_test.sv
`timescale 1ns / 100ps

module signed_multiword_decimal_accumulator_core_test;
  import smda_pkg::*;

  localparam int ACC_W       = WORD_W * WORDS_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  // Spare opcodes: the block must ignore them
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef struct packed {
    logic       is_sign;
    logic [3:0] digit;
    logic       last;
  } print_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] operation = OP_START;
  logic [3:0] digit = 4'd0;
  logic       negative = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       is_sign;
  logic [3:0] out_digit;
  logic       last;

  // Shadow copy of the accumulator state and the characters still owed by prints
  logic [ACC_W-1:0] model_acc = '0;
  logic [ACC_W-1:0] model_opnd = '0;
  logic             model_opnd_neg = 1'b0;
  print_char_t      expected_chars[$];
  print_char_t      oldest_char;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int cycle_count = 0;

  signed_multiword_decimal_accumulator_core #(
    .WORDS(WORDS_DEF)
  ) uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .operation_i(operation),
    .digit_i    (digit),
    .negative_i (negative),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .is_sign_o  (is_sign),
    .out_digit_o(out_digit),
    .last_o     (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: end the run if the block hangs
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Sink side: hold ready low for a requested stretch, otherwise stall at random
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      out_ready <= 1'b0;
      hold_off_left = hold_off_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare every accepted output beat against the oldest owed character
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        $error("output beat with nothing pending: is_sign %0d out_digit %0d last %0d",
               is_sign, out_digit, last);
        mismatches++;
      end else begin
        oldest_char = expected_chars.pop_front();
        if (is_sign !== oldest_char.is_sign) begin
          $error("is_sign: expected %0d, got %0d", oldest_char.is_sign, is_sign);
          mismatches++;
        end
        if (out_digit !== oldest_char.digit) begin
          $error("out_digit: expected %0d, got %0d", oldest_char.digit, out_digit);
          mismatches++;
        end
        if (last !== oldest_char.last) begin
          $error("last: expected %0d, got %0d", oldest_char.last, last);
          mismatches++;
        end
      end
    end
  end

  function automatic logic [ACC_W-1:0] signed_operand();
    return model_opnd_neg ? -model_opnd : model_opnd;
  endfunction

  // Advance the shadow state by one accepted beat; queue the characters a print owes
  task automatic calc_step(input logic [2:0] op, input logic [3:0] dig, input logic neg);
    logic [ACC_W-1:0] mag;
    logic [3:0]       dec_digits[$];
    print_char_t      ch;
    case (op)
      OP_START: begin
        model_opnd     = '0;
        model_opnd_neg = neg;
      end
      OP_DIGIT: model_opnd = model_opnd * 10 + dig;
      OP_LOAD:  model_acc = signed_operand();
      OP_ADD:   model_acc = model_acc + signed_operand();
      OP_SUB:   model_acc = model_acc - signed_operand();
      OP_PRINT: begin
        mag = model_acc[ACC_W-1] ? -model_acc : model_acc;
        if (model_acc[ACC_W-1]) begin
          ch = '{is_sign: 1'b1, digit: 4'd0, last: 1'b0};
          expected_chars = {expected_chars, ch};
        end
        // Peel digits least significant first; push_front leaves the leading one at the head
        do begin
          dec_digits.push_front(4'(mag % 10));
          mag = mag / 10;
        end while (mag != 0);
        foreach (dec_digits[i]) begin
          ch = '{is_sign: 1'b0, digit: dec_digits[i], last: (i == dec_digits.size() - 1)};
          expected_chars = {expected_chars, ch};
        end
      end
      default: ;
    endcase
  endtask

  // Offer one beat from a falling edge, hold it until taken, return at the next falling edge
  task automatic send_beat(input logic [2:0] op, input logic [3:0] dig, input logic neg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    digit     <= dig;
    negative  <= neg;
    do @(posedge clk); while (!in_ready);
    calc_step(op, dig, neg);
    if (op <= OP_PRINT) items_sent++;
    @(negedge clk);
  endtask

  function automatic logic [3:0] rand_digit();
    // Mostly decimal digits, now and then one above nine
    return ($urandom_range(7) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
  endfunction

  // Key in a value as a start beat followed by its decimal digits
  task automatic enter_operand(input logic [ACC_W-1:0] value, input logic neg);
    logic [3:0]       digs[$];
    logic [ACC_W-1:0] rest;
    rest = value;
    do begin
      digs.push_front(4'(rest % 10));
      rest = rest / 10;
    end while (rest != 0);
    send_beat(OP_START, 4'd0, neg);
    foreach (digs[i]) send_beat(OP_DIGIT, digs[i], 1'b0);
  endtask

  // Wait for every owed character, then return at a falling edge
  task automatic drain_prints();
    while (expected_chars.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Each operation at least once, zero after reset, digits above nine, spare opcodes
  task automatic test_operations();
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_START, 4'd15, 1'b1);
    send_beat(OP_DIGIT, 4'd1, 1'b0);
    send_beat(OP_DIGIT, 4'd2, 1'b1);
    send_beat(OP_LOAD, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_START, 4'd0, 1'b0);
    send_beat(OP_DIGIT, 4'd15, 1'b0);
    send_beat(OP_ADD, 4'd9, 1'b1);
    send_beat(OP_PRINT, 4'd15, 1'b1);
    send_beat(OP_START, 4'd0, 1'b1);
    send_beat(OP_DIGIT, 4'd9, 1'b0);
    send_beat(OP_SUB, 4'd0, 1'b0);
    send_beat(OP_SPARE6, 4'd15, 1'b1);
    send_beat(OP_SPARE7, 4'd5, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    // Digit without a fresh start keeps extending the old operand
    send_beat(OP_DIGIT, 4'd0, 1'b0);
    send_beat(OP_LOAD, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
  endtask

  // Most negative value, largest positive value, minus one, wrap on add
  task automatic test_extremes();
    logic [ACC_W-1:0] most_neg;
    most_neg = '0;
    most_neg[ACC_W-1] = 1'b1;
    enter_operand(most_neg, 1'b0);
    send_beat(OP_LOAD, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_START, 4'd0, 1'b0);
    send_beat(OP_DIGIT, 4'd1, 1'b0);
    send_beat(OP_SUB, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_ADD, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_START, 4'd0, 1'b1);
    send_beat(OP_DIGIT, 4'd1, 1'b0);
    send_beat(OP_LOAD, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
  endtask

  // Hold the sink off while long prints queue up, so the input stalls
  task automatic test_backpressure();
    hold_off_left = 400;
    enter_operand({$urandom(), $urandom(), $urandom(), $urandom()}, 1'b1);
    send_beat(OP_LOAD, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_SUB, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    send_beat(OP_PRINT, 4'd0, 1'b0);
    in_valid <= 1'b0;
    drain_prints();
  endtask

  // Mostly well-formed operand sequences with random content, some noise and broken ones
  task automatic test_random_mix(input int n_items);
    int target;
    int pick;
    int n_digits;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        send_beat(3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      end else if (pick < 18) begin
        // Broken sequence: digits or a print with no start beat
        if ($urandom_range(1)) send_beat(OP_DIGIT, rand_digit(), 1'($urandom_range(1)));
        else send_beat(OP_PRINT, 4'($urandom_range(15)), 1'($urandom_range(1)));
      end else begin
        send_beat(OP_START, 4'($urandom_range(15)), 1'($urandom_range(1)));
        n_digits = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
        repeat (n_digits) send_beat(OP_DIGIT, rand_digit(), 1'($urandom_range(1)));
        send_beat(3'(OP_LOAD + $urandom_range(2)), 4'($urandom_range(15)),
                  1'($urandom_range(1)));
        if ($urandom_range(1)) send_beat(OP_PRINT, 4'($urandom_range(15)), 1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    send_idle_pct = 19;
    recv_idle_pct = 49;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_operations();
    test_extremes();
    test_random_mix(60);

    send_idle_pct = 49;
    recv_idle_pct = 19;
    test_backpressure();
    test_random_mix(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_mix(60);

    in_valid <= 1'b0;
    drain_prints();
    // Allow a trailing print conversion to show up if one was started in error
    repeat (300) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
